@@ rtl/iirl_pkg.sv @@
// shared types and constants of the indexed insert/remove list
package iirl_pkg;

  localparam int CAPACITY   = 64;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 7;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int GRP_SIZE   = 8;
  localparam int NUM_GRPS   = CAPACITY / GRP_SIZE;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_REDUCE
  } state_e;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

@@ rtl/iirl_cell.sv @@
// one list slot: shifts with its neighbors on insert and remove
module iirl_cell (
  input  logic                        clk_i,
  input  logic [iirl_pkg::IDX_W-1:0]  idx_i,
  input  iirl_pkg::cmd_t              cmd_i,
  input  logic [iirl_pkg::VAL_W-1:0]  left_i,
  input  logic [iirl_pkg::VAL_W-1:0]  right_i,
  output logic [iirl_pkg::VAL_W-1:0]  value_o,
  output logic [iirl_pkg::VAL_W-1:0]  tap_o
);
  import iirl_pkg::*;

  logic [VAL_W-1:0] value_q, value_d;
  logic [POS_W-1:0] idx_ext;
  logic             at_pos, above_pos;

  assign idx_ext   = POS_W'(idx_i);
  assign at_pos    = (idx_ext == cmd_i.pos);
  assign above_pos = (idx_ext > cmd_i.pos);

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (at_pos) begin
        value_d = cmd_i.value;
      end else if (above_pos) begin
        value_d = left_i;
      end
    end else if (cmd_i.rem) begin
      if (at_pos || above_pos) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tap_o   = (cmd_i.rem && at_pos) ? value_q : '0;

endmodule

@@ rtl/indexed_insert_remove_list.sv @@
// top level of the indexed insert/remove list
//
// Ordered list of up to 64 32-bit values held in a row of cells. An insert
// (tuser 0) places the value at a position from 0 to the count and moves
// later entries up; a remove (tuser 1) takes out the entry at a position
// below the count and moves later entries down. Every input beat gives one
// output beat with status (ok, bad index, full), the new count and the
// removed value (zero unless a remove succeeded). All cells shift in the
// cycle the beat is accepted; the removed value is gathered by a two-level
// registered OR tree over the cells. A new beat is accepted only in idle,
// not in the reduce step, once the result register is free or being taken.
module indexed_insert_remove_list (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // position [6:0], new_value [38:7], zero [39]
  input  logic [iirl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op [0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [1:0], count [8:2], taken_value [40:9], zero [47:41]
  output logic [iirl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import iirl_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  status_e             pend_status_q, pend_status_d;
  logic [VAL_W-1:0]    grp_q [NUM_GRPS];
  logic [VAL_W-1:0]    grp_d [NUM_GRPS];
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic [VAL_W-1:0]    out_taken_q;
  logic [VAL_W-1:0]    tree_or;

  logic                in_acc, load_out;
  logic                op;
  logic [POS_W-1:0]    pos;
  logic [VAL_W-1:0]    new_value;
  cmd_t                cmd;
  status_e             status_now;

  logic [VAL_W-1:0]    cell_value [CAPACITY];
  logic [VAL_W-1:0]    cell_tap   [CAPACITY];

  assign op        = s_axis_tuser;
  assign pos       = s_axis_tdata[POS_W-1:0];
  assign new_value = s_axis_tdata[POS_W+VAL_W-1:POS_W];

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // status check and cell command
  always_comb begin
    status_now = ST_OK;
    cnt_d      = cnt_q;
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.pos    = pos;
    cmd.value  = new_value;
    if (op == OP_INSERT) begin
      if (pos > cnt_q) begin
        status_now = ST_BAD_INDEX;
      end else if (cnt_q == CNT_W'(CAPACITY)) begin
        status_now = ST_FULL;
      end else begin
        cmd.ins = in_acc;
        if (in_acc) cnt_d = cnt_q + CNT_W'(1);
      end
    end else begin
      if (pos >= cnt_q) begin
        status_now = ST_BAD_INDEX;
      end else begin
        cmd.rem = in_acc;
        if (in_acc) cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = new_value;
    end else begin : g_mid_l
      assign left_v = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_value[g];
    end else begin : g_mid_r
      assign right_v = cell_value[g+1];
    end
    iirl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_value[g]),
      .tap_o   (cell_tap[g])
    );
  end

  // first tree level: or of each group of cells
  always_comb begin
    for (int gi = 0; gi < NUM_GRPS; gi++) begin
      grp_d[gi] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        grp_d[gi] = grp_d[gi] | cell_tap[gi*GRP_SIZE + k];
      end
    end
  end

  always_comb begin
    tree_or = '0;
    for (int gi = 0; gi < NUM_GRPS; gi++) begin
      tree_or = tree_or | grp_q[gi];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_REDUCE;
      end
      S_REDUCE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
      end
      S_REDUCE: begin
        load_out = 1'b1;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign pend_status_d = in_acc ? status_now : pend_status_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    if (in_acc) begin
      for (int gi = 0; gi < NUM_GRPS; gi++) begin
        grp_q[gi] <= grp_d[gi];
      end
    end
    if (load_out) begin
      out_status_q <= pend_status_q;
      out_cnt_q    <= cnt_q;
      out_taken_q  <= tree_or;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - STATUS_W - CNT_W - VAL_W)'(0),
                          out_taken_q, out_cnt_q, out_status_q};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_REDUCE))
    else $error("accepted beat not followed by reduce");

  a_valid_after_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_REDUCE))
    else $error("result shown without reduce step");

  a_taken_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_taken_q != '0)) |-> (out_status_q == ST_OK))
    else $error("nonzero removed value on failed operation");
`endif

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for the indexed insert/remove list
`timescale 1ns / 100ps

module tb_top;
  import iirl_pkg::*;

  localparam int MAX_CYCLES  = 400000;
  localparam int RAND_ITEMS  = 950;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic             op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct {
    status_e          status;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] taken;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  list_cmd_t    cmd_q[$];
  list_result_t result_q[$];
  list_result_t want;

  logic [VAL_W-1:0] list_mem [CAPACITY];
  int               list_len = 0;
  int               gen_len = 0;
  int               err_cnt = 0;
  int               cycle_cnt = 0;
  int               burst_left = 0;
  int               gap_left = 0;
  int               rdy_cycles = 0;
  int               rdy_pct = 100;

  indexed_insert_remove_list u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // list behavior: shift on insert/remove, report status and new count
  function automatic list_result_t apply_list_op(logic op, logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] value);
    list_result_t res;
    res.status = ST_OK;
    res.taken  = '0;
    if (op == OP_INSERT) begin
      if (int'(pos) > list_len) begin
        res.status = ST_BAD_INDEX;
      end else if (list_len >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (int j = list_len; j > int'(pos); j--) list_mem[j] = list_mem[j-1];
        list_mem[IDX_W'(pos)] = value;
        list_len++;
      end
    end else begin
      if (int'(pos) >= list_len) begin
        res.status = ST_BAD_INDEX;
      end else begin
        res.taken = list_mem[IDX_W'(pos)];
        list_len--;
        for (int j = int'(pos); j < list_len; j++) list_mem[j] = list_mem[j+1];
      end
    end
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  // sender: bursts of beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(apply_list_op(s_axis_tuser, s_axis_tdata[POS_W-1:0],
                                         s_axis_tdata[POS_W+VAL_W-1:POS_W]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          list_cmd_t c;
          c = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, c.value, c.pos};
          s_axis_tuser  <= c.op;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready rate changes over stretches of cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rdy_cycles == 0) begin
        rdy_cycles <= $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: begin
            rdy_pct <= 100;
          end
          1: begin
            rdy_pct <= 75;
          end
          2: begin
            rdy_pct <= 40;
          end
          default: begin
            rdy_pct <= 10;
          end
        endcase
      end else begin
        rdy_cycles <= rdy_cycles - 1;
      end
      m_axis_tready <= ($urandom_range(0, 99) < rdy_pct);
    end
  end

  // result beat checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[8:2] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_axis_tdata[8:2]);
          err_cnt++;
        end
        if (m_axis_tdata[40:9] !== want.taken) begin
          $error("taken_value: expected %h, got %h", want.taken, m_axis_tdata[40:9]);
          err_cnt++;
        end
      end
    end
  end

  task automatic queue_cmd(logic op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] value);
    list_cmd_t c;
    c.op    = op;
    c.pos   = pos;
    c.value = value;
    cmd_q.push_back(c);
    if (op == OP_INSERT) begin
      if (int'(pos) <= gen_len && gen_len < CAPACITY) gen_len++;
    end else if (int'(pos) < gen_len) begin
      gen_len--;
    end
  endtask

  task automatic queue_random(int insert_pct);
    int               r;
    logic             op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    r  = $urandom_range(0, 99);
    if (r < 10 || (op == OP_REMOVE && gen_len == 0)) begin
      pos = POS_W'($urandom_range(0, 127));
    end else if (r < 25) begin
      pos = POS_W'((op == OP_INSERT) ? gen_len : gen_len - 1);
    end else if (r < 35) begin
      pos = 0;
    end else begin
      pos = POS_W'((op == OP_INSERT) ? $urandom_range(0, gen_len)
                                     : $urandom_range(0, gen_len - 1));
    end
    r = $urandom_range(0, 99);
    if (r < 10) value = '0;
    else if (r < 20) value = '1;
    else value = $urandom;
    queue_cmd(op, pos, value);
  endtask

  task automatic wait_drained();
    while (cmd_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(negedge clk_i);
  endtask

  initial begin
    int rand_cnt;
    int phase_len;
    int pct;
    rand_cnt = 0;
    // empty list, out-of-range and short-list cases
    queue_cmd(OP_REMOVE, 7'd0, 32'h0000_0000);
    queue_cmd(OP_REMOVE, 7'd127, 32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 7'd1, 32'hDEAD_BEEF);
    queue_cmd(OP_INSERT, 7'd0, 32'hFFFF_FFFF);
    queue_cmd(OP_INSERT, 7'd1, 32'h0000_0000);
    queue_cmd(OP_INSERT, 7'd0, 32'h8000_0001);
    queue_cmd(OP_INSERT, 7'd1, 32'h1234_5678);
    queue_cmd(OP_INSERT, 7'd127, 32'hA5A5_A5A5);
    queue_cmd(OP_INSERT, 7'd5, 32'h5A5A_5A5A);
    queue_cmd(OP_INSERT, 7'd64, 32'h0F0F_0F0F);
    queue_cmd(OP_REMOVE, 7'd4, 32'h0000_0000);
    queue_cmd(OP_REMOVE, 7'd64, 32'h0000_0000);
    queue_cmd(OP_REMOVE, 7'd1, 32'hFFFF_FFFF);
    queue_cmd(OP_REMOVE, 7'd2, 32'h0000_0000);
    queue_cmd(OP_REMOVE, 7'd0, 32'h0000_0000);
    queue_cmd(OP_REMOVE, 7'd0, 32'h0000_0000);
    queue_cmd(OP_REMOVE, 7'd0, 32'h0000_0000);
    queue_cmd(OP_INSERT, 7'd0, 32'h7FFF_FFFF);
    queue_cmd(OP_REMOVE, 7'd0, 32'h0000_0000);
    wait_drained();

    // fill to capacity, then hit the full list
    while (gen_len < CAPACITY) begin
      queue_random(100);
      rand_cnt++;
    end
    queue_cmd(OP_INSERT, 7'd65, $urandom);
    queue_cmd(OP_INSERT, 7'd64, $urandom);
    queue_cmd(OP_INSERT, 7'd0, $urandom);
    queue_cmd(OP_REMOVE, 7'd64, 32'h0000_0000);
    queue_cmd(OP_REMOVE, 7'd63, 32'h0000_0000);
    queue_cmd(OP_INSERT, 7'd63, $urandom);
    rand_cnt += 6;
    wait_drained();

    while (gen_len > 0) begin
      queue_random(0);
      rand_cnt++;
    end

    while (rand_cnt < RAND_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0: begin
          pct = 85;
        end
        1: begin
          pct = 15;
        end
        default: begin
          pct = 50;
        end
      endcase
      repeat (phase_len) begin
        queue_random(pct);
        rand_cnt++;
      end
      while (cmd_q.size() > 32) @(negedge clk_i);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ indexed_insert_remove_list.f @@
rtl/iirl_pkg.sv
rtl/iirl_cell.sv
rtl/indexed_insert_remove_list.sv
tb/tb_top.sv
